// ----- hw/rtl/lotg_pkg.sv -----
`default_nettype none

package lotg_pkg;

    localparam int REPORT_SLOTS_DEF = 64;
    localparam int GRID_X_CELLS_DEF = 2048;
    localparam int GRID_Y_CELLS_DEF = 512;
    localparam int CELL_CM_DEF      = 10;

    localparam int WORD_W     = 64;
    localparam int BITPOS_W   = 6;
    localparam int DIV_W      = 17;
    localparam int WIDE_W     = 24;
    localparam int RAD_W      = 9;
    localparam int DX_W       = 10;
    localparam int R2_W       = 18;
    localparam int ROOT_W     = 9;
    localparam int COUNT_W    = 7;
    localparam int SIZE_W     = 13;
    localparam int SLOT_W     = 6;
    // smallest offset that keeps every biased divider numerator non-negative
    localparam int OFF_SPAN   = 33279;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 14;

    localparam logic signed [12:0] ZONE_X_MIN_RST  = -13'sd2000;
    localparam logic [13:0]        ZONE_X_MAX_RST  = 14'd10000;
    localparam logic [11:0]        ZONE_Y_HALF_RST = 12'd2000;
    localparam logic [9:0]         VEH_LEN_RST     = 10'd400;
    localparam logic [8:0]         VEH_HW_RST      = 9'd100;
    localparam logic [8:0]         RADAR_R_RST     = 9'd50;
    localparam logic [8:0]         LIDAR_R_RST     = 9'd50;
    localparam logic [12:0]        DIM_LIMIT_RST   = 13'd300;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZONE_X_MIN      = 4'd0,
        REG_ZONE_X_MAX      = 4'd1,
        REG_ZONE_Y_HALF     = 4'd2,
        REG_VEHICLE_LENGTH  = 4'd3,
        REG_VEHICLE_HALF_W  = 4'd4,
        REG_RADAR_RADIUS    = 4'd5,
        REG_LIDAR_RADIUS    = 4'd6,
        REG_DIM_LIMIT       = 4'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        OP_POINT  = 2'd0,
        OP_RADAR  = 2'd1,
        OP_LIDAR  = 2'd2,
        OP_UNUSED = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PT_DIV,
        ST_PT_ADR,
        ST_PT_RD,
        ST_PT_WR,
        ST_G_SETUP,
        ST_G_BOUND,
        ST_ROW_DX,
        ST_ROW_SQ,
        ST_ROW_SQRT,
        ST_ROW_BND,
        ST_ROW_ADR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic [1:0]          operation;
        logic signed [15:0]  pos_x;
        logic signed [15:0]  pos_y;
        logic [SIZE_W-1:0]   size_x;
        logic [SIZE_W-1:0]   size_y;
        logic                frame_end;
    } t_in_item;

    typedef struct packed {
        logic                accepted;
        logic [SLOT_W-1:0]   slot;
        logic [SIZE_W-1:0]   size_x_out;
        logic [SIZE_W-1:0]   size_y_out;
        logic [COUNT_W-1:0]  accepted_count;
        logic                last_of_frame;
    } t_out_item;

endpackage

`default_nettype wire

// ----- hw/rtl/lotg_ram.sv -----
`default_nettype none

module lotg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lotg_cdiv.sv -----
`default_nettype none

module lotg_cdiv
    import lotg_pkg::*;
#(
    parameter int DIVISOR = CELL_CM_DEF
) (
    input  wire logic [DIV_W-1:0] i_num,
    output logic      [DIV_W-1:0] o_quo
);

    // reciprocal rounded up, wide enough to be exact for every numerator
    localparam int SHIFT = DIV_W + $clog2(DIVISOR);
    localparam int PROD_W = DIV_W + SHIFT + 1;
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;

    logic [PROD_W-1:0] prod;

    assign prod  = PROD_W'(i_num) * PROD_W'(RECIP);
    assign o_quo = prod[SHIFT +: DIV_W];

endmodule

`default_nettype wire

// ----- hw/rtl/lotg_isqrt.sv -----
`default_nettype none

module lotg_isqrt
    import lotg_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [R2_W-1:0]   i_radicand,
    output logic                   o_done,
    output logic      [ROOT_W-1:0] o_root
);

    localparam int CNT_W = $clog2(ROOT_W + 1);
    localparam logic [R2_W:0] BIT_START = (R2_W + 1)'(1) << (2 * (ROOT_W - 1));

    logic [R2_W:0]  r_x, r_res, r_bit;
    logic [CNT_W-1:0] r_cnt;
    logic           r_busy, r_done;
    logic [R2_W:0]  trial;
    logic           ge;

    assign trial = r_res + r_bit;
    assign ge    = r_x >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(ROOT_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // one result bit per cycle, restoring digit recurrence
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= (R2_W + 1)'(i_radicand);
            r_res <= '0;
            r_bit <= BIT_START;
        end else if (r_busy) begin
            if (ge) begin
                r_x   <= r_x - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];

endmodule

`default_nettype wire

// ----- hw/rtl/lidar_occupancy_track_gate.sv -----
`default_nettype none

// Lidar points mark CELL_CM-square cells in a radar and a lidar occupancy bitmap held in two
// single-port RAMs of 64-bit words; radar tracks and lidar objects are confirmed when a marked
// cell corner lies strictly inside the gate radius, and take a report slot. One item is in work
// at a time. A point goes through divide, address, read and write back; one outside the zone,
// in the ego box or off the grid stops after address. A track or object works through the grid
// rows within the radius; each row runs an iterative square root and then reads the RAM words
// spanned by its cell interval one at a time, stopping at the first hit. A track or object
// with frame_end clears its map with one RAM write per cycle, over all GRID_X_CELLS *
// GRID_Y_CELLS / 64 words (16384 by default), and after reset both maps are cleared the same
// way; no item is taken during a clear, configuration writes are.
module lidar_occupancy_track_gate
    import lotg_pkg::*;
#(
    parameter int REPORT_SLOTS = REPORT_SLOTS_DEF,
    parameter int GRID_X_CELLS = GRID_X_CELLS_DEF,
    parameter int GRID_Y_CELLS = GRID_Y_CELLS_DEF,
    parameter int CELL_CM      = CELL_CM_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_item,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int MAP_BITS  = GRID_X_CELLS * GRID_Y_CELLS;
    localparam int MAP_WORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
    localparam int AW        = $clog2(MAP_WORDS);
    localparam int BIT_W     = $clog2(MAP_BITS);
    localparam int IX_W      = $clog2(GRID_X_CELLS);
    localparam int OFF_Q     = (OFF_SPAN + CELL_CM - 1) / CELL_CM;

    localparam logic signed [WIDE_W-1:0] OFF_W    = WIDE_W'(OFF_Q * CELL_CM);
    localparam logic signed [WIDE_W-1:0] OFFQ_W   = WIDE_W'(OFF_Q);
    localparam logic signed [WIDE_W-1:0] C_W      = WIDE_W'(CELL_CM);
    localparam logic signed [WIDE_W-1:0] ONE_W    = WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] HALFX_W  = WIDE_W'(GRID_X_CELLS / 2);
    localparam logic signed [WIDE_W-1:0] HALFY_W  = WIDE_W'(GRID_Y_CELLS / 2);
    localparam logic signed [WIDE_W-1:0] XMAX_W   = WIDE_W'(GRID_X_CELLS - 1);
    localparam logic signed [WIDE_W-1:0] YMAX_W   = WIDE_W'(GRID_Y_CELLS - 1);
    localparam logic signed [WIDE_W-1:0] XORG_W   = WIDE_W'((GRID_X_CELLS / 2) * CELL_CM);

    // configuration
    logic signed [12:0] r_zone_x_min;
    logic [13:0]        r_zone_x_max;
    logic [11:0]        r_zone_y_half;
    logic [9:0]         r_veh_len;
    logic [8:0]         r_veh_hw;
    logic [RAD_W-1:0]   r_radar_r;
    logic [RAD_W-1:0]   r_lidar_r;
    logic [SIZE_W-1:0]  r_dim_limit;

    t_state                    r_state, n_state;
    t_in_item                  r_item, n_item;
    logic signed [WIDE_W-1:0]  r_pcx, n_pcx, r_pcy, n_pcy;
    logic                      r_pt_ok, n_pt_ok;
    logic [AW-1:0]             r_addr, n_addr;
    logic [BITPOS_W-1:0]       r_bitpos, n_bitpos;
    logic [R2_W-1:0]           r_r2, n_r2;
    logic signed [WIDE_W-1:0]  r_ixlo, n_ixlo, r_ixhi, n_ixhi;
    logic [IX_W-1:0]           r_ix, n_ix;
    logic signed [DX_W-1:0]    r_dx, n_dx;
    logic [BIT_W-1:0]          r_rbase, n_rbase;
    logic [ROOT_W-1:0]         r_root, n_root;
    logic signed [WIDE_W-1:0]  r_iylo, n_iylo, r_iyhi, n_iyhi;
    logic [BIT_W-1:0]          r_blo, n_blo, r_bhi, n_bhi;
    logic [AW-1:0]             r_clr_addr, n_clr_addr;
    logic                      r_clr_radar, n_clr_radar, r_clr_lidar, n_clr_lidar;
    logic [COUNT_W-1:0]        r_rad_cnt, n_rad_cnt, r_lid_cnt, n_lid_cnt;
    logic                      r_hit, n_hit;
    logic                      r_out_valid, n_out_valid;
    t_out_item                 r_out_item, n_out_item;

    // datapath
    logic signed [WIDE_W-1:0]  px_w, py_w, rad_w, s_w, ix_w;
    logic signed [WIDE_W-1:0]  zxmin_w, zxmax_w, zyh_w, vlen_w, vhw_w;
    logic signed [WIDE_W-1:0]  qa_w, qb_w, lo_a_w, hi_b_w, cy_lo_w, cy_hi_w;
    logic signed [WIDE_W-1:0]  pix_w, piy_w, dx_full;
    logic signed [2*DX_W-1:0]  dx_sq;
    logic [DIV_W-1:0]          div_a, div_b, quo_a, quo_b;
    logic [RAD_W-1:0]          rad;
    logic                      is_lidar, in_zone, in_car, out_free, item_ok;
    logic [COUNT_W-1:0]        cnt, cnt_next;
    logic [R2_W-1:0]           rem_c;
    logic                      sq_start, sq_done;
    logic [ROOT_W-1:0]         sq_root;
    logic [BIT_W-1:0]          pt_bit;
    logic [AW-1:0]             wlo, whi;
    logic [BITPOS_W-1:0]       lo_sh, hi_sh;
    logic [WORD_W-1:0]         scan_mask, scan_word;
    logic                      scan_hit;
    logic [SIZE_W-1:0]         sx_sel, sy_sel;

    // map RAMs share one address
    logic [AW-1:0]             ram_addr;
    logic                      we_radar, we_lidar;
    logic [WORD_W-1:0]         wd_radar, wd_lidar, rd_radar, rd_lidar, pt_mask;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_x_min  <= ZONE_X_MIN_RST;
            r_zone_x_max  <= ZONE_X_MAX_RST;
            r_zone_y_half <= ZONE_Y_HALF_RST;
            r_veh_len     <= VEH_LEN_RST;
            r_veh_hw      <= VEH_HW_RST;
            r_radar_r     <= RADAR_R_RST;
            r_lidar_r     <= LIDAR_R_RST;
            r_dim_limit   <= DIM_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_ZONE_X_MIN:     r_zone_x_min  <= signed'(i_cfg_data[12:0]);
                REG_ZONE_X_MAX:     r_zone_x_max  <= i_cfg_data[13:0];
                REG_ZONE_Y_HALF:    r_zone_y_half <= i_cfg_data[11:0];
                REG_VEHICLE_LENGTH: r_veh_len     <= i_cfg_data[9:0];
                REG_VEHICLE_HALF_W: r_veh_hw      <= i_cfg_data[8:0];
                REG_RADAR_RADIUS:   r_radar_r     <= i_cfg_data[RAD_W-1:0];
                REG_LIDAR_RADIUS:   r_lidar_r     <= i_cfg_data[RAD_W-1:0];
                REG_DIM_LIMIT:      r_dim_limit   <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    assign is_lidar = (r_item.operation == OP_LIDAR);
    assign rad      = is_lidar ? r_lidar_r : r_radar_r;
    assign px_w     = WIDE_W'(r_item.pos_x);
    assign py_w     = WIDE_W'(r_item.pos_y);
    assign rad_w    = WIDE_W'(rad);
    assign s_w      = WIDE_W'(r_root);
    assign ix_w     = WIDE_W'(r_ix);
    assign zxmin_w  = WIDE_W'(r_zone_x_min);
    assign zxmax_w  = WIDE_W'(r_zone_x_max);
    assign zyh_w    = WIDE_W'(r_zone_y_half);
    assign vlen_w   = WIDE_W'(r_veh_len);
    assign vhw_w    = WIDE_W'(r_veh_hw);

    assign in_zone = (px_w > zxmin_w) && (px_w < zxmax_w) && (py_w < zyh_w) && (py_w > -zyh_w);
    assign in_car  = (px_w > 0) && (px_w < vlen_w) && (py_w < vhw_w) && (py_w > -vhw_w);

    // two shared constant dividers, numerators absolute for a point and biased non-negative for a gate
    always_comb begin
        div_a = '0;
        div_b = '0;
        case (r_state)
            ST_PT_DIV: begin
                div_a = DIV_W'((px_w < 0) ? -px_w : px_w);
                div_b = DIV_W'((py_w < 0) ? -py_w : py_w);
            end
            ST_G_SETUP: begin
                div_a = DIV_W'(px_w - rad_w + OFF_W);
                div_b = DIV_W'(px_w + rad_w + OFF_W + C_W - 1);
            end
            ST_ROW_BND: begin
                div_a = DIV_W'(py_w - s_w + OFF_W + C_W - 1);
                div_b = DIV_W'(py_w + s_w + OFF_W);
            end
            default: ;
        endcase
    end

    lotg_cdiv #(.DIVISOR(CELL_CM)) u_div_a (.i_num(div_a), .o_quo(quo_a));
    lotg_cdiv #(.DIVISOR(CELL_CM)) u_div_b (.i_num(div_b), .o_quo(quo_b));

    assign qa_w    = WIDE_W'(quo_a);
    assign qb_w    = WIDE_W'(quo_b);
    assign lo_a_w  = qa_w + ONE_W - OFFQ_W + HALFX_W;
    assign hi_b_w  = qb_w - ONE_W - OFFQ_W + HALFX_W;
    assign cy_lo_w = qa_w - OFFQ_W + HALFY_W;
    assign cy_hi_w = qb_w - OFFQ_W + HALFY_W;

    assign pix_w   = r_pcx + HALFX_W;
    assign piy_w   = r_pcy + HALFY_W;
    assign pt_bit  = BIT_W'(BIT_W'(pix_w) * BIT_W'(GRID_Y_CELLS)) + BIT_W'(piy_w);

    assign dx_full = px_w + XORG_W - ix_w * C_W;
    assign dx_sq   = r_dx * r_dx;
    assign rem_c   = r_r2 - R2_W'(dx_sq) - R2_W'(1);

    assign sq_start = (r_state == ST_ROW_SQ);

    lotg_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (rem_c),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    assign wlo       = AW'(r_blo >> BITPOS_W);
    assign whi       = AW'(r_bhi >> BITPOS_W);
    assign lo_sh     = (r_addr == wlo) ? r_blo[BITPOS_W-1:0] : '0;
    assign hi_sh     = (r_addr == whi) ? r_bhi[BITPOS_W-1:0] : '1;
    assign scan_mask = ({WORD_W{1'b1}} << lo_sh) & ({WORD_W{1'b1}} >> (~hi_sh));
    assign scan_word = is_lidar ? rd_lidar : rd_radar;
    assign scan_hit  = |(scan_word & scan_mask);

    assign cnt      = is_lidar ? r_lid_cnt : r_rad_cnt;
    assign item_ok  = r_hit && (cnt < COUNT_W'(REPORT_SLOTS));
    assign cnt_next = cnt + COUNT_W'(item_ok);
    assign out_free = !r_out_valid || !i_out_stall;
    assign sx_sel   = (is_lidar && (r_item.size_x > r_dim_limit)) ? r_dim_limit : r_item.size_x;
    assign sy_sel   = (is_lidar && (r_item.size_y > r_dim_limit)) ? r_dim_limit : r_item.size_y;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_pcx       = r_pcx;
        n_pcy       = r_pcy;
        n_pt_ok     = r_pt_ok;
        n_addr      = r_addr;
        n_bitpos    = r_bitpos;
        n_r2        = r_r2;
        n_ixlo      = r_ixlo;
        n_ixhi      = r_ixhi;
        n_ix        = r_ix;
        n_dx        = r_dx;
        n_rbase     = r_rbase;
        n_root      = r_root;
        n_iylo      = r_iylo;
        n_iyhi      = r_iyhi;
        n_blo       = r_blo;
        n_bhi       = r_bhi;
        n_clr_addr  = r_clr_addr;
        n_clr_radar = r_clr_radar;
        n_clr_lidar = r_clr_lidar;
        n_rad_cnt   = r_rad_cnt;
        n_lid_cnt   = r_lid_cnt;
        n_hit       = r_hit;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        o_in_stall  = (r_state != ST_IDLE);

        case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(MAP_WORDS - 1)) begin
                    n_clr_radar = 1'b0;
                    n_clr_lidar = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_item;
                    case (i_in_item.operation)
                        OP_POINT: n_state = ST_PT_DIV;
                        OP_RADAR, OP_LIDAR: n_state = ST_G_SETUP;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PT_DIV: begin
                n_pcx   = (px_w < 0) ? -qa_w : qa_w;
                n_pcy   = (py_w < 0) ? -qb_w : qb_w;
                n_pt_ok = in_zone && !in_car;
                n_state = ST_PT_ADR;
            end
            ST_PT_ADR: begin
                n_addr   = AW'(pt_bit >> BITPOS_W);
                n_bitpos = pt_bit[BITPOS_W-1:0];
                if (r_pt_ok && pix_w >= 0 && pix_w <= XMAX_W && piy_w >= 0 && piy_w <= YMAX_W) begin
                    n_state = ST_PT_RD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PT_RD: begin
                n_state = ST_PT_WR;
            end
            ST_PT_WR: begin
                n_state = ST_IDLE;
            end
            ST_G_SETUP: begin
                n_r2   = R2_W'(rad * rad);
                n_ixlo = (lo_a_w < 0) ? '0 : lo_a_w;
                n_ixhi = (hi_b_w > XMAX_W) ? XMAX_W : hi_b_w;
                n_hit  = 1'b0;
                n_state = ST_G_BOUND;
            end
            ST_G_BOUND: begin
                n_ix = IX_W'(r_ixlo);
                if (r_ixlo > r_ixhi) begin
                    n_state = ST_RESULT;
                end else begin
                    n_state = ST_ROW_DX;
                end
            end
            ST_ROW_DX: begin
                n_dx    = DX_W'(dx_full);
                n_rbase = BIT_W'(r_ix) * BIT_W'(GRID_Y_CELLS);
                n_state = ST_ROW_SQ;
            end
            ST_ROW_SQ: begin
                n_state = ST_ROW_SQRT;
            end
            ST_ROW_SQRT: begin
                if (sq_done) begin
                    n_root  = sq_root;
                    n_state = ST_ROW_BND;
                end
            end
            ST_ROW_BND: begin
                n_iylo  = (cy_lo_w < 0) ? '0 : cy_lo_w;
                n_iyhi  = (cy_hi_w > YMAX_W) ? YMAX_W : cy_hi_w;
                n_state = ST_ROW_ADR;
            end
            ST_ROW_ADR: begin
                n_blo  = r_rbase + BIT_W'(r_iylo);
                n_bhi  = r_rbase + BIT_W'(r_iyhi);
                n_addr = AW'((r_rbase + BIT_W'(r_iylo)) >> BITPOS_W);
                if (r_iylo > r_iyhi) begin
                    if (r_ix == IX_W'(r_ixhi)) begin
                        n_state = ST_RESULT;
                    end else begin
                        n_ix    = r_ix + 1'b1;
                        n_state = ST_ROW_DX;
                    end
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                n_state = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (scan_hit) begin
                    n_hit   = 1'b1;
                    n_state = ST_RESULT;
                end else if (r_addr != whi) begin
                    n_addr  = r_addr + 1'b1;
                    n_state = ST_SCAN_RD;
                end else if (r_ix == IX_W'(r_ixhi)) begin
                    n_state = ST_RESULT;
                end else begin
                    n_ix    = r_ix + 1'b1;
                    n_state = ST_ROW_DX;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_out_valid               = 1'b1;
                    n_out_item.accepted       = item_ok;
                    n_out_item.slot           = item_ok ? cnt[SLOT_W-1:0] : '0;
                    n_out_item.size_x_out     = item_ok ? sx_sel : '0;
                    n_out_item.size_y_out     = item_ok ? sy_sel : '0;
                    n_out_item.accepted_count = cnt_next;
                    n_out_item.last_of_frame  = r_item.frame_end;
                    if (is_lidar) begin
                        n_lid_cnt = r_item.frame_end ? '0 : cnt_next;
                    end else begin
                        n_rad_cnt = r_item.frame_end ? '0 : cnt_next;
                    end
                    if (r_item.frame_end) begin
                        n_clr_addr  = '0;
                        n_clr_radar = !is_lidar;
                        n_clr_lidar = is_lidar;
                        n_state     = ST_CLEAR;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_clr_radar <= 1'b1;
            r_clr_lidar <= 1'b1;
            r_rad_cnt   <= '0;
            r_lid_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_radar <= n_clr_radar;
            r_clr_lidar <= n_clr_lidar;
            r_rad_cnt   <= n_rad_cnt;
            r_lid_cnt   <= n_lid_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_pcx      <= n_pcx;
        r_pcy      <= n_pcy;
        r_pt_ok    <= n_pt_ok;
        r_addr     <= n_addr;
        r_bitpos   <= n_bitpos;
        r_r2       <= n_r2;
        r_ixlo     <= n_ixlo;
        r_ixhi     <= n_ixhi;
        r_ix       <= n_ix;
        r_dx       <= n_dx;
        r_rbase    <= n_rbase;
        r_root     <= n_root;
        r_iylo     <= n_iylo;
        r_iyhi     <= n_iyhi;
        r_blo      <= n_blo;
        r_bhi      <= n_bhi;
        r_hit      <= n_hit;
        r_out_item <= n_out_item;
    end

    // read-modify-write for a point, zero fill during a clear
    assign pt_mask  = WORD_W'(1) << r_bitpos;
    assign ram_addr = (r_state == ST_CLEAR) ? r_clr_addr : r_addr;
    assign we_radar = ((r_state == ST_CLEAR) && r_clr_radar) || (r_state == ST_PT_WR);
    assign we_lidar = ((r_state == ST_CLEAR) && r_clr_lidar) || (r_state == ST_PT_WR);
    assign wd_radar = (r_state == ST_CLEAR) ? '0 : (rd_radar | pt_mask);
    assign wd_lidar = (r_state == ST_CLEAR) ? '0 : (rd_lidar | pt_mask);

    lotg_ram #(.WIDTH(WORD_W), .DEPTH(MAP_WORDS)) u_radar_map (
        .i_clk   (i_clk),
        .i_we    (we_radar),
        .i_addr  (ram_addr),
        .i_wdata (wd_radar),
        .o_rdata (rd_radar)
    );

    lotg_ram #(.WIDTH(WORD_W), .DEPTH(MAP_WORDS)) u_lidar_map (
        .i_clk   (i_clk),
        .i_we    (we_lidar),
        .i_addr  (ram_addr),
        .i_wdata (wd_lidar),
        .o_rdata (rd_lidar)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef ASSERT_OFF
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN_RD || r_state == ST_SCAN_CHK) |-> !(we_radar || we_lidar))
        else $error("map written during gate scan");

    a_slot_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.accepted) |->
        (r_out_item.accepted_count == COUNT_W'(r_out_item.slot) + COUNT_W'(1)))
        else $error("accepted count does not follow slot");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESULT && out_free && r_item.frame_end) |=>
        (r_state == ST_CLEAR && r_clr_addr == '0 && (r_clr_radar != r_clr_lidar)))
        else $error("frame end did not start a map clear");

    a_scan_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN_CHK) |-> (r_addr >= wlo && r_addr <= whi))
        else $error("scan address left the row span");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_lidar_occupancy_track_gate.sv -----
`timescale 1ns / 1ps

module tb_lidar_occupancy_track_gate;
    import lotg_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_OF_RANGE = 4'd15;
    localparam int X_HALF = GRID_X_CELLS_DEF / 2;
    localparam int Y_HALF = GRID_Y_CELLS_DEF / 2;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_item = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    lidar_occupancy_track_gate i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // shadow of the block's settings and state
    int zone_x_min, zone_x_max, zone_y_half, veh_len, veh_hw;
    int radar_radius, lidar_radius, dim_limit;
    int radar_slots, lidar_slots;
    bit radar_cells[int];
    bit lidar_cells[int];

    t_out_item gate_results[$];
    int        errors = 0;
    int        cycles = 0;
    bit        quiet = 1'b0;
    int        hold_req = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_lidar_occupancy_track_gate NOT OK");
            $finish;
        end
    end

    task automatic report(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic bit cell_key(input int cx, input int cy, output int key);
        int ix, iy;
        ix = cx + X_HALF;
        iy = cy + Y_HALF;
        key = ix * GRID_Y_CELLS_DEF + iy;
        return !(ix < 0 || ix >= GRID_X_CELLS_DEF || iy < 0 || iy >= GRID_Y_CELLS_DEF);
    endfunction

    function automatic bit gate_hit(input bit lidar, input int px, input int py, input int r);
        longint r2, dx, dy;
        int xlo, xhi, ylo, yhi, key;
        r2 = longint'(r) * r;
        xlo = (px - r) / CELL_CM_DEF - 1;
        xhi = (px + r) / CELL_CM_DEF + 1;
        ylo = (py - r) / CELL_CM_DEF - 1;
        yhi = (py + r) / CELL_CM_DEF + 1;
        if (xlo < -X_HALF) xlo = -X_HALF;
        if (xhi > X_HALF - 1) xhi = X_HALF - 1;
        if (ylo < -Y_HALF) ylo = -Y_HALF;
        if (yhi > Y_HALF - 1) yhi = Y_HALF - 1;
        for (int cx = xlo; cx <= xhi; cx++) begin
            dx = longint'(px) - longint'(cx) * CELL_CM_DEF;
            if (dx * dx >= r2) continue;
            for (int cy = ylo; cy <= yhi; cy++) begin
                dy = longint'(py) - longint'(cy) * CELL_CM_DEF;
                if (dx * dx + dy * dy >= r2) continue;
                if (cell_key(cx, cy, key)) begin
                    if (lidar ? lidar_cells.exists(key) : radar_cells.exists(key)) return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // updates the shadow state, returns 1 when the item gives a result
    function automatic bit gate_predict(input t_in_item it, output t_out_item res);
        int px, py, sx, sy, key, slots;
        bit lidar, ok, in_zone, in_car;
        px = it.pos_x;
        py = it.pos_y;
        sx = it.size_x;
        sy = it.size_y;
        res = '0;
        if (it.operation == OP_UNUSED) return 1'b0;
        if (it.operation == OP_POINT) begin
            in_zone = px > zone_x_min && px < zone_x_max && py < zone_y_half && py > -zone_y_half;
            in_car = px > 0 && px < veh_len && py < veh_hw && py > -veh_hw;
            if (in_zone && !in_car && cell_key(px / CELL_CM_DEF, py / CELL_CM_DEF, key)) begin
                radar_cells[key] = 1'b1;
                lidar_cells[key] = 1'b1;
            end
            return 1'b0;
        end
        lidar = (it.operation == OP_LIDAR);
        slots = lidar ? lidar_slots : radar_slots;
        ok = gate_hit(lidar, px, py, lidar ? lidar_radius : radar_radius)
             && slots < REPORT_SLOTS_DEF;
        if (lidar) begin
            if (sx > dim_limit) sx = dim_limit;
            if (sy > dim_limit) sy = dim_limit;
        end
        res.accepted = ok;
        res.slot = ok ? SLOT_W'(slots) : '0;
        res.size_x_out = ok ? SIZE_W'(sx) : '0;
        res.size_y_out = ok ? SIZE_W'(sy) : '0;
        if (ok) slots++;
        res.accepted_count = COUNT_W'(slots);
        res.last_of_frame = it.frame_end;
        if (it.frame_end) begin
            slots = 0;
            if (lidar) lidar_cells.delete();
            else radar_cells.delete();
        end
        if (lidar) lidar_slots = slots;
        else radar_slots = slots;
        return 1'b1;
    endfunction

    function automatic void shadow_config(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_ZONE_X_MIN:     zone_x_min = int'($signed(d[12:0]));
            REG_ZONE_X_MAX:     zone_x_max = d[13:0];
            REG_ZONE_Y_HALF:    zone_y_half = d[11:0];
            REG_VEHICLE_LENGTH: veh_len = d[9:0];
            REG_VEHICLE_HALF_W: veh_hw = d[8:0];
            REG_RADAR_RADIUS:   radar_radius = d[8:0];
            REG_LIDAR_RADIUS:   lidar_radius = d[8:0];
            REG_DIM_LIMIT:      dim_limit = d[12:0];
            default: ;
        endcase
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (gate_results.size() == 0) begin
                report("result with nothing expected");
            end else begin
                want = gate_results.pop_front();
                if (o_out_item.accepted !== want.accepted)
                    report($sformatf("accepted %0b want %0b", o_out_item.accepted, want.accepted));
                if (o_out_item.slot !== want.slot)
                    report($sformatf("slot %0d want %0d", o_out_item.slot, want.slot));
                if (o_out_item.size_x_out !== want.size_x_out)
                    report($sformatf("size_x %0d want %0d", o_out_item.size_x_out,
                                     want.size_x_out));
                if (o_out_item.size_y_out !== want.size_y_out)
                    report($sformatf("size_y %0d want %0d", o_out_item.size_y_out,
                                     want.size_y_out));
                if (o_out_item.accepted_count !== want.accepted_count)
                    report($sformatf("count %0d want %0d", o_out_item.accepted_count,
                                     want.accepted_count));
                if (o_out_item.last_of_frame !== want.last_of_frame)
                    report($sformatf("last %0b want %0b", o_out_item.last_of_frame,
                                     want.last_of_frame));
            end
        end
    end

    // receiver: random stall bursts, or one long hold-off on request
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                n = hold_req;
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                hold_req = 0;
                i_out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic t_in_item make_item(input t_op op, input int x, input int y,
                                           input int sx, input int sy, input bit fe);
        t_in_item it;
        it.operation = op;
        it.pos_x = 16'(x);
        it.pos_y = 16'(y);
        it.size_x = SIZE_W'(sx);
        it.size_y = SIZE_W'(sy);
        it.frame_end = fe;
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        t_out_item res;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        if (gate_predict(it, res)) gate_results = {gate_results, res};
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (gate_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_config(idx, CFG_DATA_W'(value));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(input int xmin, input int xmax, input int yh, input int vl,
                             input int vw, input int rr, input int lr, input int dl);
        wait_drained();
        write_reg(REG_ZONE_X_MIN, xmin);
        write_reg(REG_ZONE_X_MAX, xmax);
        write_reg(REG_ZONE_Y_HALF, yh);
        write_reg(REG_VEHICLE_LENGTH, vl);
        write_reg(REG_VEHICLE_HALF_W, vw);
        write_reg(REG_RADAR_RADIUS, rr);
        write_reg(REG_LIDAR_RADIUS, lr);
        write_reg(REG_DIM_LIMIT, dl);
    endtask

    // a few points around a spot, then tracks and objects near it
    task automatic send_scene(input int radius);
        int cx, cy, span;
        span = radius + 20;
        cx = $urandom_range(0, 5000) - 1500;
        cy = $urandom_range(0, 3000) - 1500;
        repeat ($urandom_range(1, 6))
            send_item(make_item(OP_POINT, cx + $urandom_range(0, 60) - 30,
                                cy + $urandom_range(0, 60) - 30, $urandom_range(0, 5000),
                                $urandom_range(0, 5000), $urandom_range(0, 1)));
        repeat ($urandom_range(1, 4))
            send_item(make_item($urandom_range(0, 1) ? OP_LIDAR : OP_RADAR,
                                cx + $urandom_range(0, 2 * span) - span,
                                cy + $urandom_range(0, 2 * span) - span,
                                $urandom_range(0, 5000), $urandom_range(0, 5000),
                                $urandom_range(0, 29) == 0));
    endtask

    task automatic send_noise();
        send_item(make_item(t_op'($urandom_range(0, 3)), $urandom_range(0, 65535),
                            $urandom_range(0, 65535), $urandom_range(0, 5000),
                            $urandom_range(0, 5000), $urandom_range(0, 19) == 0));
    endtask

    task automatic run_random(input int items, input int radius);
        int start;
        start = 0;
        while (start < items) begin
            if ($urandom_range(0, 6) == 0) begin
                send_noise();
                start++;
            end else begin
                send_scene(radius);
                start += 6;
            end
        end
    endtask

    task automatic test_directed();
        // points at zone edges, inside the ego box, and a frame end on a point
        send_item(make_item(OP_POINT, 205, 95, 0, 0, 1'b1));
        send_item(make_item(OP_POINT, 395, 0, 0, 0, 1'b0));
        send_item(make_item(OP_POINT, 9999, 1999, 0, 0, 1'b0));
        send_item(make_item(OP_POINT, 10000, 0, 0, 0, 1'b0));
        send_item(make_item(OP_POINT, -1999, -1999, 0, 0, 1'b0));
        send_item(make_item(OP_POINT, -2000, 50, 0, 0, 1'b0));
        send_item(make_item(OP_POINT, -32768, 32767, 8191, 8191, 1'b0));
        send_item(make_item(OP_POINT, 500, 300, 0, 0, 1'b0));
        // radar passes sizes, lidar clamps above the limit (sizes driven at and above it)
        send_item(make_item(OP_RADAR, 505, 305, 5000, 4096, 1'b0));
        send_item(make_item(OP_LIDAR, 500, 300, 300, 301, 1'b0));
        send_item(make_item(OP_LIDAR, 505, 300, 5000, 0, 1'b0));
        send_item(make_item(OP_RADAR, 32767, -32768, 0, 0, 1'b0));
        send_item(make_item(OP_LIDAR, -32768, 32767, 0, 0, 1'b0));
        send_item(make_item(OP_RADAR, 9999, 1999, 17, 23, 1'b0));
        send_item(make_item(OP_UNUSED, 500, 300, 0, 0, 1'b1));
        send_item(make_item(OP_RADAR, 500, 300, 1, 2, 1'b1));
        send_item(make_item(OP_RADAR, 500, 300, 1, 2, 1'b0));
        send_item(make_item(OP_LIDAR, 500, 300, 3, 4, 1'b1));
        send_item(make_item(OP_LIDAR, 500, 300, 3, 4, 1'b0));
        // register index beyond the list is ignored
        wait_drained();
        write_reg(REG_OUT_OF_RANGE, 16383);
        send_item(make_item(OP_POINT, 600, 600, 0, 0, 1'b0));
        send_item(make_item(OP_LIDAR, 600, 600, 4000, 4000, 1'b0));
        // zero radius accepts nothing
        write_all(-2000, 10000, 2000, 400, 100, 0, 0, 300);
        send_item(make_item(OP_RADAR, 600, 600, 9, 9, 1'b0));
        send_item(make_item(OP_LIDAR, 600, 600, 9, 9, 1'b1));
    endtask

    task automatic test_settings();
        write_all(-2000, 10000, 2000, 400, 100, 50, 50, 300);
        run_random(200, 50);
        write_all(-3200, 10200, 2550, 1000, 500, 30, 80, 5000);
        run_random(160, 80);
        write_all(0, 0, 0, 0, 0, 20, 20, 0);
        run_random(60, 20);
        write_all($urandom_range(0, 3200) - 3200, $urandom_range(0, 10200),
                  $urandom_range(0, 2550), $urandom_range(0, 1000), $urandom_range(0, 500),
                  $urandom_range(0, 120), $urandom_range(0, 120), $urandom_range(0, 5000));
        run_random(140, 60);
        // widest gate is slow, keep it short
        write_all(-3200, 10200, 2550, 0, 0, 500, 500, 2500);
        run_random(30, 500);
    endtask

    task automatic test_backpressure();
        write_all(-2000, 10000, 2000, 400, 100, 40, 40, 300);
        hold_req = 3000;
        repeat (4) send_scene(40);
        run_random(120, 40);
    endtask

    task automatic test_tail();
        quiet = 1'b1;
        run_random(120, 40);
    endtask

    initial begin
        zone_x_min = ZONE_X_MIN_RST;
        zone_x_max = ZONE_X_MAX_RST;
        zone_y_half = ZONE_Y_HALF_RST;
        veh_len = VEH_LEN_RST;
        veh_hw = VEH_HW_RST;
        radar_radius = RADAR_R_RST;
        lidar_radius = LIDAR_R_RST;
        dim_limit = DIM_LIMIT_RST;
        radar_slots = 0;
        lidar_slots = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_settings();
        test_backpressure();
        test_tail();
        i_in_valid <= 1'b0;
        while (gate_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_lidar_occupancy_track_gate OK");
        end else begin
            $display("tb_lidar_occupancy_track_gate NOT OK");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/lotg_pkg.sv
hw/rtl/lotg_ram.sv
hw/rtl/lotg_cdiv.sv
hw/rtl/lotg_isqrt.sv
hw/rtl/lidar_occupancy_track_gate.sv
tb/tb_lidar_occupancy_track_gate.sv
